// File: design/memory_self_test_sequencer_core_defines.svh
// Assertion helpers for the self-test sequencer; the module that asserts provides clk and arst_n.
`ifndef MEMORY_SELF_TEST_SEQUENCER_CORE_DEFINES_SVH
`define MEMORY_SELF_TEST_SEQUENCER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MSTS_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define MSTS_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: design/msts_pkg.sv
package msts_pkg;

	localparam int ADDR_BITS_DEFAULT = 24;
	localparam int DATA_BITS         = 32;
	localparam int WORDS_BITS        = 25;
	localparam int OUT_ADDR_BITS     = 24;

	localparam logic [WORDS_BITS-1:0] MEM_WORDS_RESET = 25'd2097152;

	// event codes
	localparam logic [1:0] FUNC_START    = 2'd0;
	localparam logic [1:0] FUNC_SLOT     = 2'd1;
	localparam logic [1:0] FUNC_RESPONSE = 2'd2;

	// command kinds
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	// finish status codes
	localparam logic [2:0] STATUS_PASS      = 3'd0;
	localparam logic [2:0] STATUS_DATA_LINE = 3'd1;
	localparam logic [2:0] STATUS_ADDR_LINE = 3'd2;
	localparam logic [2:0] STATUS_SCAN      = 3'd3;
	localparam logic [2:0] STATUS_SCAN_INV  = 3'd4;

	// configuration register indexes
	localparam logic REG_MEM_WORDS = 1'b0;

	typedef struct packed {
		logic [1:0]           func;
		logic [DATA_BITS-1:0] read_data;
	} evt_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [OUT_ADDR_BITS-1:0] address;
		logic [DATA_BITS-1:0]     write_data;
		logic [2:0]               status;
	} cmd_t;

endpackage

// File: design/memory_self_test_sequencer_core.sv
// Memory self-test sequencer. After a start event it drives a 32-bit word memory through
// three tests: a walking one at word 0 (write, then read back, for each of the 32 bits),
// an address-line test over every power-of-two offset below the size, and a full scan that
// writes every word with its index, then reads it, writes the inverted index and reads again.
// Each command-slot event (func 1) yields one write or read command beat on cmd, unless a
// read is outstanding or the test is idle or done; each read-data event (func 2) is checked
// against the expected word. The first mismatch, or the end of the scan, yields a finish
// beat carrying the status code. A start event restarts the test at any time. The memory
// size in words is set through the APB register at byte address 0; sizes above 2^ADDR_BITS
// are clamped. The block takes one event beat per clock while the command register is not
// stalled; each beat passes the event register and then the command register, and a stalled
// command register holds the event register, which then raises evt_stall.
`include "memory_self_test_sequencer_core_defines.svh"

module memory_self_test_sequencer_core #(
	parameter int ADDR_BITS = msts_pkg::ADDR_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// event channel
	input  logic               evt_valid,
	output logic               evt_stall,
	input  msts_pkg::evt_t     evt,
	// command channel
	output logic               cmd_valid,
	input  logic               cmd_stall,
	output msts_pkg::cmd_t     cmd,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// position must also count the 32 walking-one bits
	localparam int PW = (ADDR_BITS > 6) ? ADDR_BITS : 6;
	// compare width: holds the clamp limit and the size register
	localparam int CW = (ADDR_BITS + 1 > msts_pkg::WORDS_BITS) ? ADDR_BITS + 1
		: msts_pkg::WORDS_BITS;
	localparam logic [PW-1:0] AMASK = PW'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [CW-1:0] LIMIT = CW'(64'd1 << ADDR_BITS);
	localparam logic [PW-1:0] LAST_BIT = PW'(msts_pkg::DATA_BITS - 1);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DATA     = 3'd1;
	localparam logic [2:0] PH_ADDR_WR  = 3'd2;
	localparam logic [2:0] PH_ADDR_RD  = 3'd3;
	localparam logic [2:0] PH_SCAN_WR  = 3'd4;
	localparam logic [2:0] PH_SCAN_CHK = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	// sub-steps of one word (data-line test uses the first two, scan check all three)
	localparam logic [1:0] STEP_FIRST     = 2'd0;
	localparam logic [1:0] STEP_WRITE_INV = 2'd1;
	localparam logic [1:0] STEP_SECOND    = 2'd2;

	// configuration
	logic [msts_pkg::WORDS_BITS-1:0] mem_words_q;

	// sequencer state
	logic [2:0]    phase_q;
	logic [PW-1:0] pos_q;
	logic [1:0]    step_q;
	logic          await_q;
	logic [31:0]   expect_q;

	// event register and command register
	logic            evt_valid_s1;
	msts_pkg::evt_t  evt_s1;
	logic            cmd_valid_q;
	msts_pkg::cmd_t  cmd_q;

	logic advance;
	logic do_step;

	// next-state and result of the step
	logic [2:0]     phase_d;
	logic [PW-1:0]  pos_d;
	logic [1:0]     step_d;
	logic           await_d;
	logic [31:0]    expect_d;
	logic           emit;
	msts_pkg::cmd_t res;

	// helpers
	logic [CW-1:0]  eff_words;
	logic [CW-1:0]  pos_ext;
	logic [31:0]    pos_w;
	logic [23:0]    pos_a;
	logic [PW-1:0]  pos_shl;
	logic [PW-1:0]  pos_inc;
	logic           shl_end;
	logic           inc_end;
	logic [31:0]    bit_word;
	logic           mismatch;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == msts_pkg::REG_MEM_WORDS) ? 32'(mem_words_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_words_q <= msts_pkg::MEM_WORDS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == msts_pkg::REG_MEM_WORDS) begin
			mem_words_q <= pwdata[msts_pkg::WORDS_BITS-1:0];
		end
	end

	// ---------------- handshake ----------------
	// The command register can take a new beat when empty or draining this cycle.
	assign advance   = !cmd_valid_q || !cmd_stall;
	assign do_step   = evt_valid_s1 && advance;
	// Hold the event register while its result cannot move on.
	assign evt_stall = evt_valid_s1 && !advance;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	// ---------------- step helpers ----------------
	assign eff_words = (CW'(mem_words_q) > LIMIT) ? LIMIT : CW'(mem_words_q);
	assign pos_ext   = CW'(pos_q);
	assign pos_w     = 32'(pos_ext);
	assign pos_a     = 24'(pos_ext);
	assign pos_shl   = {pos_q[PW-2:0], 1'b0} & AMASK;
	assign pos_inc   = PW'(pos_q + PW'(1)) & AMASK;
	assign shl_end   = (pos_shl == '0) || (CW'(pos_shl) >= eff_words);
	assign inc_end   = (pos_inc == '0) || (CW'(pos_inc) >= eff_words);
	assign bit_word  = 32'd1 << pos_q[4:0];
	assign mismatch  = evt_s1.read_data != expect_q;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		step_d   = step_q;
		await_d  = await_q;
		expect_d = expect_q;
		emit     = 1'b0;
		res      = '0;
		unique case (evt_s1.func)
			msts_pkg::FUNC_START: begin
				phase_d  = PH_DATA;
				pos_d    = '0;
				step_d   = STEP_FIRST;
				await_d  = 1'b0;
				expect_d = '0;
			end
			msts_pkg::FUNC_SLOT: begin
				if (!await_q) begin
					unique case (phase_q)
						PH_DATA: begin
							expect_d = bit_word;
							emit     = 1'b1;
							if (step_q == STEP_FIRST) begin
								step_d         = STEP_WRITE_INV;
								res.kind       = msts_pkg::KIND_WRITE;
								res.write_data = bit_word;
							end else begin
								await_d  = 1'b1;
								res.kind = msts_pkg::KIND_READ;
							end
						end
						PH_ADDR_WR: begin
							emit           = 1'b1;
							res.kind       = msts_pkg::KIND_WRITE;
							res.address    = pos_a;
							res.write_data = pos_w;
							pos_d          = pos_shl;
							if (shl_end) begin
								phase_d = PH_ADDR_RD;
								pos_d   = PW'(1);
							end
						end
						PH_ADDR_RD: begin
							expect_d    = pos_w;
							await_d     = 1'b1;
							emit        = 1'b1;
							res.kind    = msts_pkg::KIND_READ;
							res.address = pos_a;
						end
						PH_SCAN_WR: begin
							emit           = 1'b1;
							res.kind       = msts_pkg::KIND_WRITE;
							res.address    = pos_a;
							res.write_data = pos_w;
							pos_d          = pos_inc;
							if (inc_end) begin
								phase_d = PH_SCAN_CHK;
								pos_d   = '0;
								step_d  = STEP_FIRST;
							end
						end
						PH_SCAN_CHK: begin
							emit        = 1'b1;
							res.address = pos_a;
							if (step_q == STEP_WRITE_INV) begin
								step_d         = STEP_SECOND;
								res.kind       = msts_pkg::KIND_WRITE;
								res.write_data = ~pos_w;
							end else begin
								expect_d = (step_q == STEP_FIRST) ? pos_w : ~pos_w;
								await_d  = 1'b1;
								res.kind = msts_pkg::KIND_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			msts_pkg::FUNC_RESPONSE: begin
				if (await_q) begin
					await_d = 1'b0;
					unique case (phase_q)
						PH_DATA: begin
							if (mismatch) begin
								emit       = 1'b1;
								res.status = msts_pkg::STATUS_DATA_LINE;
							end else begin
								step_d = STEP_FIRST;
								pos_d  = PW'(pos_q + PW'(1));
								if (pos_q >= LAST_BIT) begin
									// enter the address-line test, or skip it
									if (eff_words > CW'(1)) begin
										phase_d = PH_ADDR_WR;
										pos_d   = PW'(1);
									end else begin
										pos_d = '0;
										if (eff_words != '0) begin
											phase_d = PH_SCAN_WR;
										end else begin
											emit       = 1'b1;
											res.status = msts_pkg::STATUS_PASS;
										end
									end
								end
							end
						end
						PH_ADDR_RD: begin
							if (mismatch) begin
								emit       = 1'b1;
								res.status = msts_pkg::STATUS_ADDR_LINE;
							end else begin
								pos_d = pos_shl;
								if (shl_end) begin
									step_d = STEP_FIRST;
									pos_d  = '0;
									if (eff_words != '0) begin
										phase_d = PH_SCAN_WR;
									end else begin
										emit       = 1'b1;
										res.status = msts_pkg::STATUS_PASS;
									end
								end
							end
						end
						PH_SCAN_CHK: begin
							if (step_q == STEP_FIRST) begin
								if (mismatch) begin
									emit       = 1'b1;
									res.status = msts_pkg::STATUS_SCAN;
								end else begin
									step_d = STEP_WRITE_INV;
								end
							end else if (mismatch) begin
								emit       = 1'b1;
								res.status = msts_pkg::STATUS_SCAN_INV;
							end else begin
								step_d = STEP_FIRST;
								pos_d  = pos_inc;
								if (inc_end) begin
									emit       = 1'b1;
									res.status = msts_pkg::STATUS_PASS;
								end
							end
						end
						default: begin
						end
					endcase
					// every emit on a read response is a finish beat
					if (emit) begin
						res.kind = msts_pkg::KIND_FINISH;
						phase_d  = PH_DONE;
						step_d   = STEP_FIRST;
						await_d  = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
			cmd_valid_q  <= 1'b0;
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			step_q       <= STEP_FIRST;
			await_q      <= 1'b0;
			expect_q     <= '0;
		end else begin
			if (!evt_stall) begin
				evt_valid_s1 <= evt_valid;
			end
			if (advance) begin
				cmd_valid_q <= do_step && emit;
			end
			if (do_step) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				step_q   <= step_d;
				await_q  <= await_d;
				expect_q <= expect_d;
			end
		end
	end

	// payload registers: load the event beat on accept, the result beat on a step
	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
		if (do_step && emit) begin
			cmd_q <= res;
		end
	end

	// ---------------- checks ----------------
	`MSTS_ALWAYS(a_await_phase, !await_q || phase_q == PH_DATA || phase_q == PH_ADDR_RD || phase_q == PH_SCAN_CHK, "read pending outside a reading phase")
	`MSTS_ALWAYS(a_step_code, step_q == STEP_FIRST || step_q == STEP_WRITE_INV || step_q == STEP_SECOND, "bad sub-step")
	`MSTS_NEXT(a_finish_done, do_step && emit && res.kind == msts_pkg::KIND_FINISH, phase_q == PH_DONE && !await_q, "finish beat without done phase")
	`MSTS_NEXT(a_hold_event, evt_valid_s1 && !advance, evt_valid_s1 && $stable(evt_s1), "held event lost")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import msts_pkg::*;

	localparam int ADDR_BITS = ADDR_BITS_DEFAULT;
	// func code that the block has to ignore
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// cycles without any beat on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// settle for longer than a beat takes through the event and command registers
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 78;

	typedef enum logic [2:0] {
		PH_IDLE, PH_DATA, PH_ADDR_WR, PH_ADDR_RD, PH_SCAN_WR, PH_SCAN_CHK, PH_DONE
	} test_phase_t;

	// Everything the sequencer remembers between beats, plus its size register.
	typedef struct packed {
		logic [WORDS_BITS-1:0] words;
		test_phase_t           phase;
		logic [ADDR_BITS-1:0]  pos;
		logic [1:0]            step;
		logic                  awaiting;
		logic [DATA_BITS-1:0]  want;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_stall;
	evt_t        evt = '0;
	logic        cmd_valid;
	logic        cmd_stall = 1'b0;
	cmd_t        cmd;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Two copies of the sequencer: one steers the stimulus, one predicts the commands.
	seq_state_t plan_st;
	seq_state_t track_st;
	evt_t       pending_events[$];
	cmd_t       expected_cmds[$];
	int         events_planned = 0;
	int         events_taken = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         sender_idle_pct = 0;
	int         stall_pct = 0;
	int         response_no = 0;
	int         fail_at = 0;

	// Memory sizes visited by the random phases, extremes and the clamp case among them.
	logic [WORDS_BITS-1:0] size_plan [0:PHASES-1] = '{
		25'd3, 25'd0, 25'd1, 25'd37, 25'd16777216, 25'd2,
		25'h1FFFFFF, 25'd5, 25'd16, 25'd4, 25'd1, 25'd24
	};

	memory_self_test_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	function automatic cmd_t make_cmd(input logic [1:0] kind, input logic [ADDR_BITS-1:0] addr,
			input logic [DATA_BITS-1:0] data);
		return {kind, OUT_ADDR_BITS'(addr), data, STATUS_PASS};
	endfunction

	// End the test: park in done and emit the finish beat with its status.
	function automatic bit close_test(inout seq_state_t s, input logic [2:0] code,
			output cmd_t c);
		s.phase = PH_DONE;
		s.awaiting = 1'b0;
		s.step = '0;
		c = {KIND_FINISH, {OUT_ADDR_BITS{1'b0}}, {DATA_BITS{1'b0}}, code};
		return 1'b1;
	endfunction

	// Enter the full scan; an empty memory passes straight away.
	function automatic bit start_scan(inout seq_state_t s, input logic [WORDS_BITS-1:0] eff,
			output cmd_t c);
		s.step = '0;
		s.pos = '0;
		c = '0;
		if (eff != '0) begin
			s.phase = PH_SCAN_WR;
			return 1'b0;
		end
		return close_test(s, STATUS_PASS, c);
	endfunction

	// Advance the sequencer by one event beat; return 1 when it yields a command beat.
	function automatic bit step_sequencer(inout seq_state_t s, input evt_t ev, output cmd_t c);
		logic [WORDS_BITS-1:0] lim;
		logic [WORDS_BITS-1:0] eff;
		bit                    hit;
		lim = WORDS_BITS'(1) << ADDR_BITS;
		eff = (s.words > lim) ? lim : s.words;
		hit = 1'b0;
		c = '0;
		case (ev.func)
			FUNC_START: begin
				// restart from the walking one, dropping any read in flight
				s.phase = PH_DATA;
				s.pos = '0;
				s.step = '0;
				s.awaiting = 1'b0;
				s.want = '0;
			end
			FUNC_SLOT: begin
				if (!s.awaiting) begin
					case (s.phase)
						PH_DATA: begin
							s.want = DATA_BITS'(1) << s.pos[4:0];
							if (s.step == 2'd0) begin
								s.step = 2'd1;
								c = make_cmd(KIND_WRITE, '0, s.want);
							end else begin
								s.awaiting = 1'b1;
								c = make_cmd(KIND_READ, '0, '0);
							end
							hit = 1'b1;
						end
						PH_ADDR_WR: begin
							c = make_cmd(KIND_WRITE, s.pos, DATA_BITS'(s.pos));
							s.pos = s.pos << 1;
							if (s.pos == '0 || s.pos >= eff) begin
								s.phase = PH_ADDR_RD;
								s.pos = ADDR_BITS'(1);
							end
							hit = 1'b1;
						end
						PH_ADDR_RD: begin
							s.want = DATA_BITS'(s.pos);
							s.awaiting = 1'b1;
							c = make_cmd(KIND_READ, s.pos, '0);
							hit = 1'b1;
						end
						PH_SCAN_WR: begin
							c = make_cmd(KIND_WRITE, s.pos, DATA_BITS'(s.pos));
							s.pos = s.pos + 1'b1;
							if (s.pos == '0 || s.pos >= eff) begin
								s.phase = PH_SCAN_CHK;
								s.pos = '0;
								s.step = '0;
							end
							hit = 1'b1;
						end
						PH_SCAN_CHK: begin
							if (s.step == 2'd1) begin
								s.step = 2'd2;
								c = make_cmd(KIND_WRITE, s.pos, ~DATA_BITS'(s.pos));
							end else begin
								s.want = (s.step == 2'd0) ?
									DATA_BITS'(s.pos) : ~DATA_BITS'(s.pos);
								s.awaiting = 1'b1;
								c = make_cmd(KIND_READ, s.pos, '0);
							end
							hit = 1'b1;
						end
						default: ;
					endcase
				end
			end
			FUNC_RESPONSE: begin
				if (s.awaiting) begin
					s.awaiting = 1'b0;
					case (s.phase)
						PH_DATA: begin
							if (ev.read_data != s.want) begin
								hit = close_test(s, STATUS_DATA_LINE, c);
							end else begin
								s.step = '0;
								s.pos = s.pos + 1'b1;
								if (s.pos >= DATA_BITS) begin
									// address-line test only when there is more than one word
									if (eff > 1) begin
										s.phase = PH_ADDR_WR;
										s.pos = ADDR_BITS'(1);
									end else begin
										hit = start_scan(s, eff, c);
									end
								end
							end
						end
						PH_ADDR_RD: begin
							if (ev.read_data != s.want) begin
								hit = close_test(s, STATUS_ADDR_LINE, c);
							end else begin
								s.pos = s.pos << 1;
								if (s.pos == '0 || s.pos >= eff)
									hit = start_scan(s, eff, c);
							end
						end
						PH_SCAN_CHK: begin
							if (s.step == 2'd0) begin
								if (ev.read_data != s.want)
									hit = close_test(s, STATUS_SCAN, c);
								else
									s.step = 2'd1;
							end else if (ev.read_data != s.want) begin
								hit = close_test(s, STATUS_SCAN_INV, c);
							end else begin
								s.step = '0;
								s.pos = s.pos + 1'b1;
								if (s.pos == '0 || s.pos >= eff)
									hit = close_test(s, STATUS_PASS, c);
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Queue one event beat and keep the planning copy in step with it.
	task automatic push_event(input logic [1:0] func, input logic [DATA_BITS-1:0] data);
		evt_t ev;
		cmd_t ignored;
		ev.func = func;
		ev.read_data = data;
		void'(step_sequencer(plan_st, ev, ignored));
		pending_events.push_back(ev);
		events_planned++;
	endtask

	// Random traffic: mostly the well-formed exchange a healthy memory would give,
	// with one planted bad read per test now and then, plus stray beats.
	task automatic plan_items(input int count);
		logic [1:0]            func;
		logic [DATA_BITS-1:0]  data;
		logic [WORDS_BITS-1:0] eff;
		int                    total;
		repeat (count) begin
			data = $urandom;
			if ($urandom_range(0, 199) == 0) begin
				func = FUNC_START;
			end else if ($urandom_range(0, 99) < 5) begin
				func = 2'($urandom_range(1, 3));
			end else if (plan_st.phase == PH_IDLE || plan_st.phase == PH_DONE) begin
				func = FUNC_START;
			end else if (plan_st.awaiting) begin
				func = FUNC_RESPONSE;
				data = plan_st.want;
			end else begin
				func = FUNC_SLOT;
			end
			if (func == FUNC_START) begin
				// pick which read of the coming test to corrupt, or none at all
				eff = (plan_st.words > (WORDS_BITS'(1) << ADDR_BITS)) ?
					(WORDS_BITS'(1) << ADDR_BITS) : plan_st.words;
				total = DATA_BITS + 2 * ((eff > 400) ? 400 : int'(eff));
				for (longint k = 1; k < eff; k = k << 1)
					total++;
				fail_at = $urandom_range(0, 2 * total);
				response_no = 0;
			end else if (func == FUNC_RESPONSE && plan_st.awaiting) begin
				if (response_no == fail_at)
					data = data ^ (DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1));
				response_no++;
			end
			push_event(func, data);
		end
	endtask

	// Hold until every beat went in and every command came out, then let the pipe empty.
	task automatic drain_traffic();
		while (events_taken != events_planned || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the size register, then read it back.
	task automatic write_mem_words(input logic [WORDS_BITS-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MEM_WORDS, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		plan_st.words = value;
		track_st.words = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata != 32'(value))
			report_mismatch($sformatf("mem_words read back %0d, wrote %0d", prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stimulus sequencing: reset, directed beats, then random phases.
	initial begin
		plan_st = '0;
		plan_st.words = MEM_WORDS_RESET;
		track_st = plan_st;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// idle sequencer: slot, read data and the unused code all do nothing
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_RESPONSE, 32'h0);
		push_event(FUNC_UNUSED, 32'hFFFF_FFFF);
		// first walking-one bit, with stray read data before the read is issued
		push_event(FUNC_START, 32'h0);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_RESPONSE, 32'hFFFF_FFFF);
		push_event(FUNC_SLOT, 32'h0);
		// slot while a read is pending gives nothing
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_RESPONSE, 32'h1);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_SLOT, 32'h0);
		// restart with a read outstanding drops it
		push_event(FUNC_START, 32'h0);
		push_event(FUNC_RESPONSE, 32'h0);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_SLOT, 32'h0);
		// data-line failure, then slot and read data while done
		push_event(FUNC_RESPONSE, 32'hFFFF_FFFF);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_RESPONSE, 32'h1);
		// data-line failure on an all-zero word
		push_event(FUNC_START, 32'hFFFF_FFFF);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_SLOT, 32'h0);
		push_event(FUNC_RESPONSE, 32'h0);
		drain_traffic();

		// each phase changes the size, possibly mid-test, and the idling pattern
		for (int p = 0; p < PHASES; p++) begin
			write_mem_words(size_plan[p]);
			case (p % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 53; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 53; end
				default: begin sender_idle_pct = 23; stall_pct = 23; end
			endcase
			plan_items(ITEMS_PER_PHASE);
			drain_traffic();
		end

		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// Event driver: advance to the next beat once the current one is taken or none is up.
	always @(posedge clk) begin
		if (arst_n && (!evt_valid || !evt_stall)) begin
			if (pending_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				evt_valid <= 1'b1;
				evt <= pending_events.pop_front();
			end else begin
				evt_valid <= 1'b0;
			end
		end
		cmd_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Monitor: check the command beat first, since an event taken at this edge
	// cannot show up before the next one.
	always @(posedge clk) begin
		cmd_t want_cmd;
		cmd_t new_cmd;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				if (expected_cmds.size() == 0) begin
					report_mismatch($sformatf("unexpected command beat kind %0d addr %0h",
						cmd.kind, cmd.address));
				end else begin
					want_cmd = expected_cmds.pop_front();
					if (cmd.kind != want_cmd.kind)
						report_mismatch($sformatf("kind %0d, want %0d", cmd.kind, want_cmd.kind));
					if (cmd.address != want_cmd.address)
						report_mismatch($sformatf("address %0h, want %0h",
							cmd.address, want_cmd.address));
					if (cmd.write_data != want_cmd.write_data)
						report_mismatch($sformatf("write_data %0h, want %0h",
							cmd.write_data, want_cmd.write_data));
					if (cmd.status != want_cmd.status)
						report_mismatch($sformatf("status %0d, want %0d",
							cmd.status, want_cmd.status));
				end
			end
			if (evt_valid && !evt_stall) begin
				if (step_sequencer(track_st, evt, new_cmd))
					expected_cmds.push_back(new_cmd);
				events_taken++;
			end
		end
	end

	// Watchdog: give up when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (evt_valid && !evt_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

endmodule

// File: sim.f
+incdir+design
design/msts_pkg.sv
design/memory_self_test_sequencer_core.sv
verif/tb_top.sv
